// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/wnms_pkg.sv
// Package: constants, types and controller interface of the suppression block
`default_nettype none
package wnms_pkg;
    localparam int RADIUS_CAP = 16;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int VALUE_BITS = 16;
    localparam int FRAC_BITS  = VALUE_BITS - 8;
    localparam int STORE_ROWS = 2 * RADIUS_CAP + 1;
    localparam int CNT_W      = 11;
    localparam int COORD_W    = 10;
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int XADDR_W    = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = SLOT_W + XADDR_W;
    localparam int RAD_W      = 5;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 11;

    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_RADIUS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic emit_due;
        logic last_issue;
        logic out_full;
    } status_t;
endpackage
`default_nettype wire

// File: rtl/wnms_ctrl.sv
// Controller: sequences load, window sweep, drain and result hand-off
`default_nettype none
module wnms_ctrl
    import wnms_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.emit_due)
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/wnms_datapath.sv
// Datapath: registers, stream counters, line store, window sweep and result register
`default_nettype none
module wnms_datapath
    import wnms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic                  op,
    input  wire logic [VALUE_BITS-1:0] response,
    input  wire logic                  cfg_we,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COORD_W-1:0]         col,
    output logic [COORD_W-1:0]         row,
    output logic                       is_corner,
    output logic                       frame_end
);
    logic [7:0]       thr_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [CFG_W-1:0] fw_reg, fh_reg;

    logic [CNT_W-1:0]  c_reg, rr_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [VALUE_BITS-1:0] mem [STORE_ROWS*MAX_WIDTH];
    logic [VALUE_BITS-1:0] rdata_reg;

    logic [COORD_W-1:0] x_reg, y_reg, x0_reg, x1_reg, y1_reg, wx_reg, wy_reg;
    logic [SLOT_W-1:0]  wslot_reg;
    logic               pend_reg;
    logic [COORD_W-1:0] px_reg, py_reg, bx_reg, by_reg;
    logic [VALUE_BITS-1:0] best_reg, center_reg;
    logic               found_reg, fe_reg;

    logic                  out_valid_reg;
    logic [COORD_W-1:0]    col_reg, row_reg;
    logic                  corner_reg, fend_reg;

    logic [CNT_W-1:0]   w, h;
    logic [RAD_W-1:0]   r;
    logic [CNT_W:0]     c_inc, rr_inc, wr_sum, hr_sum;
    logic [CNT_W-1:0]   xs, ys;
    logic               emit_due, in_frame;
    logic [COORD_W-1:0] x, y, x0, x1, y0, y1;
    logic [CNT_W:0]     xr, yr;
    logic [CNT_W-1:0]   d0;
    logic [SLOT_W:0]    slot0;
    logic [SLOT_W-1:0]  slot_step;

    always_comb
    begin
        if (fw_reg == '0)
            w = CNT_W'(1);
        else if (fw_reg > CNT_W'(MAX_WIDTH))
            w = CNT_W'(MAX_WIDTH);
        else
            w = fw_reg;
        if (fh_reg == '0)
            h = CNT_W'(1);
        else if (fh_reg > CNT_W'(MAX_HEIGHT))
            h = CNT_W'(MAX_HEIGHT);
        else
            h = fh_reg;
        r = (rad_reg > RAD_W'(RADIUS_CAP)) ? RAD_W'(RADIUS_CAP) : rad_reg;

        c_inc  = {1'b0, c_reg} + 1'b1;
        rr_inc = {1'b0, rr_reg} + 1'b1;
        wr_sum = {1'b0, w} + (CNT_W+1)'(r);
        hr_sum = {1'b0, h} + (CNT_W+1)'(r);

        in_frame = (c_reg < w) && (rr_reg < h);
        xs = c_reg - CNT_W'(r);
        ys = rr_reg - CNT_W'(r);
        emit_due = (c_reg >= CNT_W'(r)) && (rr_reg >= CNT_W'(r)) && (xs < w) && (ys < h);
        x = xs[COORD_W-1:0];
        y = ys[COORD_W-1:0];

        x0 = (xs >= CNT_W'(r)) ? COORD_W'(xs - CNT_W'(r)) : '0;
        y0 = (ys >= CNT_W'(r)) ? COORD_W'(ys - CNT_W'(r)) : '0;
        xr = {1'b0, xs} + (CNT_W+1)'(r);
        yr = {1'b0, ys} + (CNT_W+1)'(r);
        x1 = (xr < (CNT_W+1)'(w)) ? COORD_W'(xr) : COORD_W'(w - 1'b1);
        y1 = (yr < (CNT_W+1)'(h)) ? COORD_W'(yr) : COORD_W'(h - 1'b1);

        d0 = rr_reg - CNT_W'(y0);
        if ((SLOT_W+1)'(slot_reg) >= (SLOT_W+1)'(d0))
            slot0 = (SLOT_W+1)'(slot_reg) - (SLOT_W+1)'(d0);
        else
            slot0 = (SLOT_W+1)'(slot_reg) + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(d0);

        slot_step = (wslot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0 : wslot_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 8'd70;
            rad_reg <= RAD_W'(12);
            fw_reg  <= CFG_W'(640);
            fh_reg  <= CFG_W'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_data[7:0];
                REG_RADIUS:    rad_reg <= cfg_data[RAD_W-1:0];
                REG_WIDTH:     fw_reg  <= cfg_data;
                REG_HEIGHT:    fh_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg    <= '0;
            rr_reg   <= '0;
            slot_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (c_inc >= wr_sum)
            begin
                c_reg <= '0;
                if (rr_inc >= hr_sum)
                begin
                    rr_reg   <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    rr_reg   <= rr_inc[CNT_W-1:0];
                    slot_reg <= (slot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                c_reg <= c_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_frame)
        begin
            mem[{slot_reg, c_reg[XADDR_W-1:0]}] <= op ? '0 : response;
        end
        if (cmd.issue)
        begin
            rdata_reg <= mem[{wslot_reg, wx_reg[XADDR_W-1:0]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= x;
            y_reg     <= y;
            x0_reg    <= x0;
            x1_reg    <= x1;
            y1_reg    <= y1;
            wx_reg    <= x0;
            wy_reg    <= y0;
            wslot_reg <= slot0[SLOT_W-1:0];
            fe_reg    <= (x == COORD_W'(w - 1'b1)) && (y == COORD_W'(h - 1'b1));
        end
        else if (cmd.issue)
        begin
            px_reg <= wx_reg;
            py_reg <= wy_reg;
            if (wx_reg == x1_reg)
            begin
                wx_reg    <= x0_reg;
                wy_reg    <= wy_reg + 1'b1;
                wslot_reg <= slot_step;
            end
            else
            begin
                wx_reg <= wx_reg + 1'b1;
            end
        end
        if (pend_reg)
        begin
            if (!found_reg || rdata_reg > best_reg)
            begin
                best_reg <= rdata_reg;
                bx_reg   <= px_reg;
                by_reg   <= py_reg;
            end
            if (px_reg == x_reg && py_reg == y_reg)
            begin
                center_reg <= rdata_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.issue;
            if (cmd.load)
                found_reg <= 1'b0;
            else if (pend_reg)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            col_reg    <= x_reg;
            row_reg    <= y_reg;
            fend_reg   <= fe_reg;
            corner_reg <= (center_reg[VALUE_BITS-1:FRAC_BITS] > thr_reg)
                          && (bx_reg == x_reg) && (by_reg == y_reg);
        end
    end

    assign status.emit_due   = emit_due;
    assign status.last_issue = (wx_reg == x1_reg) && (wy_reg == y1_reg);
    assign status.out_full   = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign col       = col_reg;
    assign row       = row_reg;
    assign is_corner = corner_reg;
    assign frame_end = fend_reg;
endmodule
`default_nettype wire

// File: rtl/window_non_max_suppression.sv
// Top level: streaming window non-maximum suppression of corner responses
// Items without a decision are accepted back to back; one with a decision holds the input through
// the window sweep of N = (x1-x0+1)*(y1-y0+1) line store reads, up to 33*33, then drain and emit.
// The decision is registered when hand-off is granted; hand-off waits while a result is held.
// Reset is asynchronous active low: counters and control clear, registers take defaults.
// The line store is not cleared; entries are valid once written by the stream.
`default_nettype none
`include "assert_macros.svh"
module window_non_max_suppression
    import wnms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic [VALUE_BITS-1:0] response,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COORD_W-1:0]         col,
    output logic [COORD_W-1:0]         row,
    output logic                       is_corner,
    output logic                       frame_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    wnms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wnms_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (op),
        .response  (response),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .col       (col),
        .row       (row),
        .is_corner (is_corner),
        .frame_end (frame_end)
    );

    `ASSERT_IMPLY(a_emit_free, clk, rst_n, cmd.emit, !out_valid)
    `ASSERT_NEXT(a_sweep_start, clk, rst_n, cmd.load && status.emit_due, cmd.issue)
    `ASSERT_IMPLY(a_no_load_busy, clk, rst_n, cmd.issue || cmd.emit, in_stall)
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for window_non_max_suppression: random and directed frames checked by a predictor
`timescale 1ns / 1ps
module tb_top;
    import wnms_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               is_corner;
        logic               frame_end;
    } decision_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  op = 1'b0;
    logic [VALUE_BITS-1:0] response = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COORD_W-1:0]    col;
    logic [COORD_W-1:0]    row;
    logic                  is_corner;
    logic                  frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    window_non_max_suppression u_top (.*);

    always #6 clk = ~clk;

    // predictor state
    logic [VALUE_BITS-1:0] line_mem [0:STORE_ROWS*MAX_WIDTH-1];
    int unsigned           cur_col = 0;
    int unsigned           cur_row = 0;
    logic [7:0]            thr_reg = 8'd70;
    logic [4:0]            rad_reg = 5'd12;
    logic [10:0]           width_reg = 11'd640;
    logic [10:0]           height_reg = 11'd480;

    decision_t             pending_decisions[$];
    int                    fail_count = 0;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    items_sent = 0;
    int                    quiet_cycles = 0;

    function automatic int unsigned sat_size(logic [10:0] v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [VALUE_BITS-1:0] mem_at(int unsigned y, int unsigned x);
        return line_mem[(y % STORE_ROWS) * MAX_WIDTH + x];
    endfunction

    function automatic logic window_winner(int unsigned x, int unsigned y, int unsigned w,
                                           int unsigned h, int unsigned r);
        int unsigned y0, y1, x0, x1, bx, by;
        logic [VALUE_BITS-1:0] best, v;
        logic found;
        y0 = (y >= r) ? y - r : 0;
        y1 = (y + r < h) ? y + r : h - 1;
        x0 = (x >= r) ? x - r : 0;
        x1 = (x + r < w) ? x + r : w - 1;
        found = 1'b0;
        best = '0;
        bx = 0;
        by = 0;
        for (int unsigned wy = y0; wy <= y1; wy++)
        begin
            for (int unsigned wx = x0; wx <= x1; wx++)
            begin
                v = mem_at(wy, wx);
                if (!found || v > best)
                begin
                    found = 1'b1;
                    best = v;
                    bx = wx;
                    by = wy;
                end
            end
        end
        v = mem_at(y, x);
        return (v[VALUE_BITS-1:FRAC_BITS] > thr_reg) && bx == x && by == y;
    endfunction

    task automatic predict_decision(logic item_op, logic [VALUE_BITS-1:0] item_resp);
        int unsigned w, h, r, x, y;
        decision_t d;
        w = sat_size(width_reg, MAX_WIDTH);
        h = sat_size(height_reg, MAX_HEIGHT);
        r = (rad_reg > RADIUS_CAP) ? RADIUS_CAP : rad_reg;
        if (cur_col < w && cur_row < h)
            line_mem[(cur_row % STORE_ROWS) * MAX_WIDTH + cur_col] = item_op ? '0 : item_resp;
        if (cur_col >= r && cur_row >= r)
        begin
            x = cur_col - r;
            y = cur_row - r;
            if (x < w && y < h)
            begin
                d.col = x[COORD_W-1:0];
                d.row = y[COORD_W-1:0];
                d.is_corner = window_winner(x, y, w, h, r);
                d.frame_end = (x == w - 1 && y == h - 1);
                pending_decisions.insert(pending_decisions.size(), d);
            end
        end
        if (cur_col + 1 >= w + r)
        begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= h + r) ? 0 : cur_row + 1;
        end
        else
            cur_col = cur_col + 1;
    endtask

    // called at a rising edge; returns at the edge that accepted the transaction, or after an idle gap
    task automatic send_pixel(logic item_op, logic [VALUE_BITS-1:0] item_resp);
        int gap;
        in_valid <= 1'b1;
        op <= item_op;
        response <= item_resp;
        do
            @(posedge clk);
        while (in_stall);
        predict_decision(item_op, item_resp);
        items_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_reg = data[7:0];
            REG_RADIUS:    rad_reg = data[4:0];
            REG_WIDTH:     width_reg = data;
            REG_HEIGHT:    height_reg = data;
            default:       ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_frame(int thr, int rad, int w, int h);
        wait_drained();
        write_reg(REG_THRESHOLD, CFG_W'(thr));
        write_reg(REG_RADIUS, CFG_W'(rad));
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        if ($urandom_range(9) == 0)
            write_reg(IDX_W'($urandom_range(4, 7)), CFG_W'($urandom));
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_response(int mode);
        case (mode)
            0: return VALUE_BITS'($urandom);
            1: return {8'($urandom_range(0, 3) * 30 + 40), 8'($urandom_range(0, 1) * 8'hff)};
            default: return {8'($urandom_range(60, 90)), 8'($urandom)};
        endcase
    endfunction

    // stream one full padded frame with the current settings
    task automatic stream_frame(int mode);
        int unsigned w, h, r;
        logic in_frame;
        w = sat_size(width_reg, MAX_WIDTH);
        h = sat_size(height_reg, MAX_HEIGHT);
        r = (rad_reg > RADIUS_CAP) ? RADIUS_CAP : rad_reg;
        for (int unsigned y = 0; y < h + r; y++)
        begin
            for (int unsigned x = 0; x < w + r; x++)
            begin
                in_frame = (x < w && y < h);
                if (in_frame)
                    send_pixel($urandom_range(9) == 0, pick_response(mode));
                else
                    send_pixel($urandom_range(7) != 0, VALUE_BITS'($urandom));
            end
        end
    endtask

    task automatic test_extremes();
        set_frame(0, 0, 2, 1);
        send_pixel(1'b0, 16'hffff);
        send_pixel(1'b0, 16'h0000);
        set_frame(255, 0, 2, 1);
        send_pixel(1'b0, 16'hffff);
        send_pixel(1'b0, 16'h0100);
        set_frame(10, 1, 3, 1);
        for (int i = 0; i < 8; i++)
            send_pixel(i >= 3, 16'h5000);
        set_frame(0, 1, 2, 2);
        send_pixel(1'b1, 16'hffff);
        send_pixel(1'b0, 16'h0100);
        send_pixel(1'b0, 16'hffff);
        for (int i = 0; i < 6; i++)
            send_pixel(1'b0, 16'hffff);
    endtask

    task automatic test_saturation();
        set_frame(0, 31, 0, 0);
        stream_frame(1);
    endtask

    task automatic test_random_frames();
        int rad, w, h, thr, base;
        base = items_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 64; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 64; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            while (items_sent < base + 160 * (phase + 1))
            begin
                if ($urandom_range(7) == 0)
                begin
                    rad = $urandom_range(5, 16);
                    w = $urandom_range(1, 3);
                    h = $urandom_range(1, 2);
                end
                else
                begin
                    rad = $urandom_range(0, 3);
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 8);
                end
                case ($urandom_range(3))
                    0: thr = 0;
                    1: thr = 255;
                    default: thr = $urandom_range(30, 100);
                endcase
                set_frame(thr, rad, w, h);
                stream_frame($urandom_range(2));
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    always @(posedge clk)
    begin
        decision_t d;
        if (out_valid && !out_stall)
        begin
            if (pending_decisions.size() == 0)
            begin
                $display("%0t: unexpected decision col=%0d row=%0d", $time, col, row);
                fail_count++;
            end
            else
            begin
                d = pending_decisions.pop_front();
                if (col !== d.col || row !== d.row || is_corner !== d.is_corner
                    || frame_end !== d.frame_end)
                begin
                    $display("%0t: expected col=%0d row=%0d corner=%0b end=%0b, got col=%0d row=%0d corner=%0b end=%0b",
                             $time, d.col, d.row, d.is_corner, d.frame_end,
                             col, row, is_corner, frame_end);
                    fail_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_extremes();
        test_saturation();
        test_random_frames();
        wait_drained();
        repeat (1200) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
